// File: design/bpr_pkg.sv
package bpr_pkg;

  // Group geometry
  localparam int unsigned GroupPixels = 16;
  localparam int unsigned PlaneWordW  = 16;
  localparam int unsigned PlaneFields = 8;

  // Remap table
  localparam int unsigned ColorW     = 8;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned NumBanks   = GroupPixels / 2;

  // Field widths
  localparam int unsigned PlaneCntW = 4;
  localparam int unsigned ValidPixW = 5;

  // Stream widths: entry_index, entry_value, eight plane words, valid_pixels
  localparam int unsigned InFieldsW = 2 * ColorW + PlaneFields * PlaneWordW + ValidPixW;
  localparam int unsigned InTdataW  = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutTdataW = PlaneFields * PlaneWordW;

  localparam logic [PlaneCntW-1:0] PlaneCountReset = 4'd4;

  typedef enum logic {
    FUNC_LOAD    = 1'b0,
    FUNC_CONVERT = 1'b1
  } func_e;

  typedef logic [PlaneFields-1:0][PlaneWordW-1:0] plane_words_t;
  typedef logic [GroupPixels-1:0][ColorW-1:0]     pixel_colors_t;
  typedef logic [PlaneFields-1:0]                 plane_mask_t;

endpackage

// File: design/bpr_gather.sv
module bpr_gather (
  input  bpr_pkg::plane_words_t  words_i,
  input  bpr_pkg::plane_mask_t   plane_en_i,
  output bpr_pkg::pixel_colors_t colors_o
);

  // Collect one color index per pixel: plane p gives index bit p
  always_comb begin
    colors_o = '0;
    for (int i = 0; i < bpr_pkg::GroupPixels; i++) begin
      for (int p = 0; p < bpr_pkg::PlaneFields; p++) begin
        colors_o[i][p] = words_i[p][bpr_pkg::GroupPixels-1-i] & plane_en_i[p];
      end
    end
  end

endmodule

// File: design/bpr_lut.sv
module bpr_lut (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [bpr_pkg::ColorW-1:0] waddr_i,
  input  logic [bpr_pkg::ColorW-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [bpr_pkg::ColorW-1:0] raddr_a_i,
  input  logic [bpr_pkg::ColorW-1:0] raddr_b_i,
  output logic [bpr_pkg::ColorW-1:0] rdata_a_o,
  output logic [bpr_pkg::ColorW-1:0] rdata_b_o
);

  logic [bpr_pkg::ColorW-1:0] mem_q [bpr_pkg::TableDepth];
  logic [bpr_pkg::ColorW-1:0] rdata_a_q;
  logic [bpr_pkg::ColorW-1:0] rdata_b_q;

  // One write port, two registered read ports; hold read data while stalled
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: design/bpr_scatter.sv
module bpr_scatter (
  input  bpr_pkg::pixel_colors_t           mapped_i,
  input  bpr_pkg::plane_mask_t             plane_en_i,
  input  logic [bpr_pkg::ValidPixW-1:0]    valid_pixels_i,
  output bpr_pkg::plane_words_t            planes_o
);

  // Spread index bit p of each valid pixel into output plane p
  always_comb begin
    planes_o = '0;
    for (int i = 0; i < bpr_pkg::GroupPixels; i++) begin
      for (int p = 0; p < bpr_pkg::PlaneFields; p++) begin
        planes_o[p][bpr_pkg::GroupPixels-1-i] = mapped_i[i][p] & plane_en_i[p]
                                                & (bpr_pkg::ValidPixW'(i) < valid_pixels_i);
      end
    end
  end

endmodule

// File: design/bitplane_palette_remap.sv
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/s_axis_tready tuser = func, tdata = load or plane fields
// m_axis    out  m_axis_tvalid/m_axis_tready tdata = out_plane_0..7
// cfg       in   cfg_we_i                    cfg_wdata_i = plane_count
//
// One beat is taken every cycle while s_axis_tready is high. A convert beat passes
// through the input register, the table read and the output register in that order.
// The table is replicated in eight two-port banks so all sixteen pixel lookups
// of a group happen in the same cycle. Load beats write every bank and give no result.
// Reset clears the pipeline valids and sets plane_count to 4; the table is not cleared.
// A stall on m_axis holds the output register; earlier stages keep filling, and
// s_axis_tready drops in the same cycle once all three stages are full.
module bitplane_palette_remap #(
  parameter int unsigned MAX_PLANES = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bpr_pkg::PlaneCntW-1:0]     cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] entry_index, [15:8] entry_value, [31:16] plane_word_0 ... [143:128]
  // plane_word_7, [148:144] valid_pixels, [151:149] zero
  input  logic [bpr_pkg::InTdataW-1:0]      s_axis_tdata,
  // [0] func
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] out_plane_0, [31:16] out_plane_1 ... [127:112] out_plane_7
  output logic [bpr_pkg::OutTdataW-1:0]     m_axis_tdata
);

  localparam int unsigned WordsLsb = 2 * bpr_pkg::ColorW;
  localparam int unsigned ValidLsb = WordsLsb + bpr_pkg::PlaneFields * bpr_pkg::PlaneWordW;

  logic [bpr_pkg::PlaneCntW-1:0] plane_count_q;

  logic                             s0_valid_q;
  bpr_pkg::func_e                   s0_func_q;
  logic [bpr_pkg::ColorW-1:0]       s0_index_q;
  logic [bpr_pkg::ColorW-1:0]       s0_value_q;
  bpr_pkg::plane_words_t            s0_words_q;
  logic [bpr_pkg::ValidPixW-1:0]    s0_vpix_q;

  logic                             s1_valid_q;
  logic [bpr_pkg::ValidPixW-1:0]    s1_vpix_q;

  logic                             out_valid_q;
  bpr_pkg::plane_words_t            out_planes_q;

  logic                             out_free;
  logic                             s1_free;
  logic                             s0_free;
  logic                             lut_we;
  logic                             lut_re;
  bpr_pkg::plane_mask_t             plane_en;
  bpr_pkg::pixel_colors_t           colors;
  bpr_pkg::pixel_colors_t           mapped;
  bpr_pkg::plane_words_t            planes_d;

  // Plane count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_count_q <= bpr_pkg::PlaneCountReset;
    end else if (cfg_we_i) begin
      plane_count_q <= cfg_wdata_i;
    end
  end

  // Planes in use, capped by the build limit
  always_comb begin
    plane_en = '0;
    for (int p = 0; p < bpr_pkg::PlaneFields; p++) begin
      plane_en[p] = (p < MAX_PLANES) && (bpr_pkg::PlaneCntW'(p) < plane_count_q);
    end
  end

  // Stage flow control
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_free       = !s1_valid_q || out_free;
  assign s0_free       = !s0_valid_q || s1_free;
  assign s_axis_tready = s0_free;

  assign lut_we = s0_valid_q && (s0_func_q == bpr_pkg::FUNC_LOAD) && s1_free;
  assign lut_re = s0_valid_q && (s0_func_q == bpr_pkg::FUNC_CONVERT) && s1_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s0_free) begin
      s0_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_free && s_axis_tvalid) begin
      s0_func_q  <= bpr_pkg::func_e'(s_axis_tuser);
      s0_index_q <= s_axis_tdata[bpr_pkg::ColorW-1:0];
      s0_value_q <= s_axis_tdata[WordsLsb-1:bpr_pkg::ColorW];
      s0_words_q <= s_axis_tdata[ValidLsb-1:WordsLsb];
      s0_vpix_q  <= s_axis_tdata[ValidLsb+bpr_pkg::ValidPixW-1:ValidLsb];
    end
  end

  bpr_gather u_gather (
    .words_i    (s0_words_q),
    .plane_en_i (plane_en),
    .colors_o   (colors)
  );

  // Table banks, two pixels per bank
  for (genvar b = 0; b < bpr_pkg::NumBanks; b++) begin : g_bank
    bpr_lut u_lut (
      .clk_i     (clk_i),
      .we_i      (lut_we),
      .waddr_i   (s0_index_q),
      .wdata_i   (s0_value_q),
      .re_i      (lut_re),
      .raddr_a_i (colors[2*b]),
      .raddr_b_i (colors[2*b+1]),
      .rdata_a_o (mapped[2*b]),
      .rdata_b_o (mapped[2*b+1])
    );
  end

  // Lookup stage; load beats end here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= lut_re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lut_re) begin
      s1_vpix_q <= s0_vpix_q;
    end
  end

  bpr_scatter u_scatter (
    .mapped_i       (mapped),
    .plane_en_i     (plane_en),
    .valid_pixels_i (s1_vpix_q),
    .planes_o       (planes_d)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      out_planes_q <= planes_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_planes_q;

endmodule

// File: verif/bitplane_palette_remap_test.sv
`timescale 1ns / 1ps

module bitplane_palette_remap_test;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;

  // One input beat before packing
  typedef struct {
    bpr_pkg::func_e                func;
    logic [bpr_pkg::ColorW-1:0]    entry_index;
    logic [bpr_pkg::ColorW-1:0]    entry_value;
    bpr_pkg::plane_words_t         words;
    logic [bpr_pkg::ValidPixW-1:0] valid_pixels;
  } remap_beat_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [bpr_pkg::PlaneCntW-1:0] cfg_wdata_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  // [7:0] entry_index, [15:8] entry_value, [143:16] plane_word_0..7,
  // [148:144] valid_pixels, [151:149] zero
  logic [bpr_pkg::InTdataW-1:0]  s_axis_tdata;
  // [0] func
  logic                          s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  // [15:0] out_plane_0 ... [127:112] out_plane_7
  logic [bpr_pkg::OutTdataW-1:0] m_axis_tdata;

  // Shadow of the block: remap table, plane count, groups still to come out
  logic [bpr_pkg::ColorW-1:0]    color_map [bpr_pkg::TableDepth];
  bit                            map_written [bpr_pkg::TableDepth];
  logic [bpr_pkg::PlaneCntW-1:0] plane_cnt_q = bpr_pkg::PlaneCountReset;
  bpr_pkg::plane_words_t         pending_remaps [$];

  int unsigned fail_count       = 0;
  int unsigned results_checked  = 0;
  int unsigned loads_sent       = 0;
  int unsigned converts_sent    = 0;
  int unsigned settings_used    = 0;
  int unsigned cycle_count      = 0;
  int unsigned sink_hold_cycles = 0;
  bit          src_idle_on      = 1'b1;
  bit          sink_idle_on     = 1'b1;

  bitplane_palette_remap i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Planes in use, saturated at the number of plane words
  function automatic int unsigned planes_active();
    return (int'(plane_cnt_q) > bpr_pkg::PlaneFields) ? bpr_pkg::PlaneFields
                                                       : int'(plane_cnt_q);
  endfunction

  // Gather each valid pixel's color, look it up, scatter the new color back
  function automatic bpr_pkg::plane_words_t remap_group(bpr_pkg::plane_words_t src,
                                                        logic [bpr_pkg::ValidPixW-1:0] vp);
    bpr_pkg::plane_words_t      res;
    logic [bpr_pkg::ColorW-1:0] color;
    logic [bpr_pkg::ColorW-1:0] mapped;
    int unsigned                planes;
    int unsigned                npix;
    res    = '0;
    planes = planes_active();
    npix   = (int'(vp) > bpr_pkg::GroupPixels) ? bpr_pkg::GroupPixels : int'(vp);
    for (int unsigned pix = 0; pix < npix; pix++) begin
      color = '0;
      for (int unsigned p = 0; p < planes; p++) begin
        color[p] = src[p][bpr_pkg::GroupPixels-1-pix];
      end
      mapped = color_map[color];
      for (int unsigned p = 0; p < planes; p++) begin
        res[p][bpr_pkg::GroupPixels-1-pix] = mapped[p];
      end
    end
    return res;
  endfunction

  // Pick a table entry below span that has been loaded; entry 0 always is
  function automatic logic [bpr_pkg::ColorW-1:0] pick_written_color(int unsigned span);
    int unsigned start;
    int unsigned idx;
    start = $urandom_range(span - 1, 0);
    for (int unsigned k = 0; k < span; k++) begin
      idx = (start + k) % span;
      if (map_written[idx]) return idx[bpr_pkg::ColorW-1:0];
    end
    return '0;
  endfunction

  // Random beat; converts only look up entries that were loaded
  function automatic remap_beat_t random_beat(int unsigned load_pct);
    remap_beat_t                b;
    logic [bpr_pkg::ColorW-1:0] color;
    int unsigned                planes;
    int unsigned                npix;
    b.func = ($urandom_range(99, 0) < load_pct) ? bpr_pkg::FUNC_LOAD : bpr_pkg::FUNC_CONVERT;
    b.entry_index = bpr_pkg::ColorW'($urandom);
    b.entry_value = bpr_pkg::ColorW'($urandom);
    for (int p = 0; p < bpr_pkg::PlaneFields; p++) b.words[p] = bpr_pkg::PlaneWordW'($urandom);
    if ($urandom_range(9, 0) == 0) begin
      b.valid_pixels = bpr_pkg::ValidPixW'($urandom);
    end else begin
      b.valid_pixels = bpr_pkg::ValidPixW'($urandom_range(bpr_pkg::GroupPixels, 1));
    end
    if (b.func == bpr_pkg::FUNC_CONVERT) begin
      planes = planes_active();
      npix   = (int'(b.valid_pixels) > bpr_pkg::GroupPixels) ? bpr_pkg::GroupPixels
                                                              : int'(b.valid_pixels);
      if (planes != 0) begin
        for (int unsigned pix = 0; pix < npix; pix++) begin
          color = pick_written_color(1 << planes);
          for (int unsigned p = 0; p < planes; p++) begin
            b.words[p][bpr_pkg::GroupPixels-1-pix] = color[p];
          end
        end
      end
    end
    return b;
  endfunction

  // Offer one beat, hold it until accepted, then update the shadow state
  task automatic send_beat(remap_beat_t b);
    logic [bpr_pkg::InTdataW-1:0] data;
    data = '0;
    data[bpr_pkg::InFieldsW-1:0] = {b.valid_pixels, b.words, b.entry_value, b.entry_index};
    if (src_idle_on && $urandom_range(4, 0) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= b.func;
    do @(posedge clk_i); while (!s_axis_tready);
    if (b.func == bpr_pkg::FUNC_LOAD) begin
      color_map[b.entry_index]   = b.entry_value;
      map_written[b.entry_index] = 1'b1;
      loads_sent++;
    end else begin
      pending_remaps.push_back(remap_group(b.words, b.valid_pixels));
      converts_sent++;
    end
  endtask

  task automatic send_load(logic [bpr_pkg::ColorW-1:0] idx, logic [bpr_pkg::ColorW-1:0] val);
    remap_beat_t b;
    b              = random_beat(100);
    b.entry_index  = idx;
    b.entry_value  = val;
    send_beat(b);
  endtask

  task automatic send_convert(bpr_pkg::plane_words_t w, logic [bpr_pkg::ValidPixW-1:0] vp);
    remap_beat_t b;
    b.func         = bpr_pkg::FUNC_CONVERT;
    b.entry_index  = bpr_pkg::ColorW'($urandom);
    b.entry_value  = bpr_pkg::ColorW'($urandom);
    b.words        = w;
    b.valid_pixels = vp;
    send_beat(b);
  endtask

  task automatic send_random(int unsigned count, int unsigned load_pct);
    repeat (count) send_beat(random_beat(load_pct));
  endtask

  // Stop offering, wait for every group to come out, then let the pipe settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_remaps.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_plane_count(logic [bpr_pkg::PlaneCntW-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    plane_cnt_q = value;
    settings_used++;
  endtask

  // Extreme indexes and values, plus the entries the directed groups use
  task automatic test_table_loads();
    send_load(8'h00, 8'hFF);
    send_load(8'hFF, 8'h00);
    send_load(8'h0F, 8'hA5);
    send_load(8'h01, 8'h5A);
  endtask

  // Reset plane count of four: wide table values, ignored planes, pixel counts
  task automatic test_directed_converts();
    send_convert('0, 5'd16);
    send_convert('1, 5'd16);
    send_convert({{4{16'hFFFF}}, 16'h0000, 16'h0000, 16'h0000, 16'h8000}, 5'd31);
    send_convert({4{$urandom}}, 5'd0);
    send_convert({{4{16'hFFFF}}, {4{16'h0000}}}, 5'd1);
  endtask

  // No planes, saturated count, full count, single plane
  task automatic test_plane_count_limits();
    write_plane_count(4'd0);
    send_convert('1, 5'd16);
    write_plane_count(4'd15);
    send_convert('0, 5'd16);
    send_convert('1, 5'd16);
    write_plane_count(4'd8);
    send_beat(random_beat(0));
    write_plane_count(4'd1);
    send_convert('1, 5'd16);
    send_convert({{7{16'hFFFF}}, 16'hAAAA}, 5'd16);
  endtask

  // Mixed loads and converts across many plane counts, with idling on both sides
  task automatic test_random_phases();
    logic [bpr_pkg::PlaneCntW-1:0] counts [12];
    counts = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd9, 4'd3, 4'd5, 4'd6, 4'd7, 4'd4, 4'd8};
    foreach (counts[i]) begin
      write_plane_count(counts[i]);
      send_random(130, 30);
    end
  endtask

  // Hold the output off for a long stretch while input keeps coming
  task automatic test_output_backpressure();
    write_plane_count(4'd8);
    src_idle_on      = 1'b0;
    sink_hold_cycles = 200;
    send_random(60, 10);
    src_idle_on      = 1'b1;
  endtask

  // Pause input until every result is out, then resume
  task automatic test_sender_pause();
    write_plane_count(4'd6);
    send_random(30, 30);
    wait_idle();
    send_random(30, 30);
  endtask

  // Back-to-back beats with both sides always ready
  task automatic test_steady_stream();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    write_plane_count(4'd8);
    send_random(250, 30);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= bpr_pkg::FUNC_LOAD;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_table_loads();
    test_directed_converts();
    test_plane_count_limits();
    test_random_phases();
    test_output_backpressure();
    test_sender_pause();
    test_steady_stream();
    wait_idle();

    $display("covered %0d table loads and %0d group conversions over %0d plane-count writes",
             loads_sent, converts_sent, settings_used);
    $display("checked %0d result beats in %0d cycles, %0d mismatches",
             results_checked, cycle_count, fail_count);
    if (fail_count == 0) begin
      $display("bitplane_palette_remap_test: PASS");
    end else begin
      $display("bitplane_palette_remap_test: FAIL");
    end
    $finish;
  end

  // Check each result beat and drive output ready with random stalls
  initial begin : result_sink
    bpr_pkg::plane_words_t want;
    int unsigned           stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (pending_remaps.size() == 0) begin
          $error("unexpected result beat, out planes %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = pending_remaps.pop_front();
          results_checked++;
          for (int p = 0; p < bpr_pkg::PlaneFields; p++) begin
            if (m_axis_tdata[p*bpr_pkg::PlaneWordW +: bpr_pkg::PlaneWordW] !== want[p]) begin
              $error("out_plane_%0d: expected %h, actual %h",
                     p, want[p], m_axis_tdata[p*bpr_pkg::PlaneWordW +: bpr_pkg::PlaneWordW]);
              fail_count++;
            end
          end
        end
      end
      if (sink_hold_cycles != 0) begin
        sink_hold_cycles--;
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(5, 0) == 0) begin
        stall_left = $urandom_range(12, 1) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // End a hung run
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending",
             cycle_count, pending_remaps.size());
    $display("bitplane_palette_remap_test: FAIL");
    $finish;
  end

endmodule
